>>> hw/rtl/vao_pkg.sv
package vao_pkg;

	localparam int VOICES   = 18;
	localparam int CHANNELS = 16;

	localparam int VOICE_W = $clog2(VOICES);
	localparam int CNT_W   = $clog2(VOICES + 1);
	localparam int STAMP_W = 32;

	localparam logic [1:0] FN_ALLOC    = 2'd0;
	localparam logic [1:0] FN_RELEASE  = 2'd1;
	localparam logic [1:0] FN_SIL_CHAN = 2'd2;
	localparam logic [1:0] FN_SIL_ALL  = 2'd3;

	localparam logic [1:0] KIND_FREE     = 2'd0;
	localparam logic [1:0] KIND_RELEASED = 2'd1;
	localparam logic [1:0] KIND_ACTIVE   = 2'd2;

	typedef struct packed {
		logic [1:0] func;
		logic [3:0] channel;
		logic [6:0] note;
	} cmd_t;

	typedef struct packed {
		logic [4:0]  voice;
		logic [1:0]  steal_kind;
		logic [17:0] affected_mask;
		logic [4:0]  active_count;
	} res_t;

	typedef struct packed {
		logic [3:0]         channel;
		logic [6:0]         note;
		logic [STAMP_W-1:0] stamp;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// Results of one pass over the voice table
	typedef struct packed {
		logic               hit;
		logic [VOICES-1:0]  mask;
		logic [CNT_W-1:0]   cnt;
		logic               free_found;
		logic [VOICE_W-1:0] free_idx;
		logic               rel_found;
		logic [VOICE_W-1:0] rel_idx;
		logic [VOICE_W-1:0] any_idx;
	} scan_t;

endpackage

>>> hw/rtl/vao_ram.sv
module vao_ram #(
	parameter int DEPTH = 18,
	parameter int WIDTH = 43,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> hw/rtl/vao_scan.sv
module vao_scan (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         clear,
	input  logic                         valid_s1,
	input  logic [vao_pkg::VOICE_W-1:0]  idx_s1,
	input  vao_pkg::entry_t              entry_s1,
	input  logic                         held_b,
	input  logic                         let_go_b,
	input  vao_pkg::cmd_t                cmd,
	input  logic                         chan_ok,
	output vao_pkg::scan_t               scan
);

	logic                         hit;
	logic                         match_chan;
	logic                         active_after;
	logic [vao_pkg::VOICES-1:0]   mask_q;
	logic [vao_pkg::CNT_W-1:0]    cnt_q;
	logic                         free_found_q;
	logic [vao_pkg::VOICE_W-1:0]  free_idx_q;
	logic                         rel_found_q;
	logic [vao_pkg::VOICE_W-1:0]  rel_idx_q;
	logic [vao_pkg::STAMP_W-1:0]  rel_stamp_q;
	logic                         any_found_q;
	logic [vao_pkg::VOICE_W-1:0]  any_idx_q;
	logic [vao_pkg::STAMP_W-1:0]  any_stamp_q;

	assign match_chan = chan_ok && (entry_s1.channel == cmd.channel);

	always_comb begin
		case (cmd.func)
			vao_pkg::FN_RELEASE:  hit = held_b && !let_go_b && match_chan &&
			                            (entry_s1.note == cmd.note);
			vao_pkg::FN_SIL_CHAN: hit = held_b && match_chan;
			vao_pkg::FN_SIL_ALL:  hit = held_b;
			default:              hit = 1'b0;
		endcase
	end

	// count the voice as it stands once this command has touched it
	assign active_after = held_b && !let_go_b && !hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q       <= '0;
			cnt_q        <= '0;
			free_found_q <= 1'b0;
			free_idx_q   <= '0;
			rel_found_q  <= 1'b0;
			rel_idx_q    <= '0;
			rel_stamp_q  <= '0;
			any_found_q  <= 1'b0;
			any_idx_q    <= '0;
			any_stamp_q  <= '0;
		end else if (clear) begin
			mask_q       <= '0;
			cnt_q        <= '0;
			free_found_q <= 1'b0;
			rel_found_q  <= 1'b0;
			any_found_q  <= 1'b0;
		end else if (valid_s1) begin
			if (hit) begin
				mask_q[idx_s1] <= 1'b1;
			end
			cnt_q <= cnt_q + vao_pkg::CNT_W'(active_after);
			if (!held_b && !free_found_q) begin
				free_found_q <= 1'b1;
				free_idx_q   <= idx_s1;
			end
			// strict compare keeps the lowest index on a tie
			if (let_go_b && (!rel_found_q || entry_s1.stamp < rel_stamp_q)) begin
				rel_found_q <= 1'b1;
				rel_idx_q   <= idx_s1;
				rel_stamp_q <= entry_s1.stamp;
			end
			if (!any_found_q || entry_s1.stamp < any_stamp_q) begin
				any_found_q <= 1'b1;
				any_idx_q   <= idx_s1;
				any_stamp_q <= entry_s1.stamp;
			end
		end
	end

	always_comb begin
		scan.hit        = valid_s1 && hit;
		scan.mask       = mask_q;
		scan.cnt        = cnt_q;
		scan.free_found = free_found_q;
		scan.free_idx   = free_idx_q;
		scan.rel_found  = rel_found_q;
		scan.rel_idx    = rel_idx_q;
		scan.any_idx    = any_idx_q;
	end

endmodule

>>> hw/rtl/voice_allocator_oldest_steal.sv
// Channel   Direction  Handshake               Payload
// command   in         start && !busy          cmd    (func, channel, note)
// result    out        done, one cycle         result (voice, steal_kind,
//                                                      affected_mask, active_count)
//
// Each item runs from accept to the next possible accept as one read of the voice
// table per voice through the single read port, then a drain of the read register,
// then a pick and write-back; no new command is taken while busy.
// busy falls in the cycle that carries done, so a new item may start then.
// arst_n clears the held and released bits, the stamp counter and all control.
// The receiver cannot stall; a result is shown for exactly one cycle.
module voice_allocator_oldest_steal (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  vao_pkg::cmd_t  cmd,
	output logic           done,
	output vao_pkg::res_t  result
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	localparam logic [vao_pkg::VOICE_W-1:0] LAST = vao_pkg::VOICE_W'(vao_pkg::VOICES - 1);

	logic [1:0]                   state_q;
	logic                         accept;
	vao_pkg::cmd_t                cmd_q;
	logic                         chan_ok_q;
	logic [vao_pkg::VOICE_W-1:0]  rd_addr_q;
	logic                         valid_s1;
	logic [vao_pkg::VOICE_W-1:0]  idx_s1;
	vao_pkg::entry_t              entry_s1;
	logic [vao_pkg::ENTRY_W-1:0]  rdata;
	logic [vao_pkg::VOICES-1:0]   held_q;
	logic [vao_pkg::VOICES-1:0]   let_go_q;
	logic [vao_pkg::STAMP_W-1:0]  stamp_q;
	logic [vao_pkg::STAMP_W-1:0]  stamp_next;
	vao_pkg::scan_t               scan;
	logic                         do_alloc;
	logic                         ram_we;
	vao_pkg::entry_t              wentry;
	logic [vao_pkg::VOICE_W-1:0]  pick;
	logic [1:0]                   kind;
	logic [vao_pkg::VOICES-1:0]   mask;
	logic [vao_pkg::CNT_W-1:0]    count;
	logic                         done_q;
	vao_pkg::res_t                result_q;

	assign accept     = start && (state_q == ST_IDLE);
	assign busy       = (state_q != ST_IDLE);
	assign stamp_next = stamp_q + 1'b1;
	assign do_alloc   = (state_q == ST_DONE) && (cmd_q.func == vao_pkg::FN_ALLOC) && chan_ok_q;
	assign ram_we     = do_alloc;
	assign entry_s1   = vao_pkg::entry_t'(rdata);

	always_comb begin
		wentry.channel = cmd_q.channel;
		wentry.note    = cmd_q.note;
		wentry.stamp   = stamp_next;
	end

	vao_ram #(
		.DEPTH (vao_pkg::VOICES),
		.WIDTH (vao_pkg::ENTRY_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (pick),
		.wdata (wentry),
		.raddr (rd_addr_q),
		.rdata (rdata)
	);

	vao_scan u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.clear    (accept),
		.valid_s1 (valid_s1),
		.idx_s1   (idx_s1),
		.entry_s1 (entry_s1),
		.held_b   (held_q[idx_s1]),
		.let_go_b (let_go_q[idx_s1]),
		.cmd      (cmd_q),
		.chan_ok  (chan_ok_q),
		.scan     (scan)
	);

	// lowest free voice, else oldest released, else oldest of all
	always_comb begin
		if (scan.free_found) begin
			pick = scan.free_idx;
			kind = vao_pkg::KIND_FREE;
		end else if (scan.rel_found) begin
			pick = scan.rel_idx;
			kind = vao_pkg::KIND_RELEASED;
		end else begin
			pick = scan.any_idx;
			kind = vao_pkg::KIND_ACTIVE;
		end
	end

	always_comb begin
		if (do_alloc) begin
			mask  = vao_pkg::VOICES'(1) << pick;
			count = scan.cnt + vao_pkg::CNT_W'(kind != vao_pkg::KIND_ACTIVE);
		end else begin
			mask  = scan.mask;
			count = scan.cnt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			rd_addr_q <= '0;
			valid_s1  <= 1'b0;
			idx_s1    <= '0;
			held_q    <= '0;
			let_go_q  <= '0;
			stamp_q   <= '0;
			done_q    <= 1'b0;
		end else begin
			done_q   <= 1'b0;
			valid_s1 <= (state_q == ST_SCAN);
			idx_s1   <= rd_addr_q;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						rd_addr_q <= '0;
						state_q   <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (rd_addr_q == LAST) begin
						state_q <= ST_DRAIN;
					end else begin
						rd_addr_q <= rd_addr_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (scan.hit) begin
				if (cmd_q.func == vao_pkg::FN_RELEASE) begin
					let_go_q[idx_s1] <= 1'b1;
				end else begin
					held_q[idx_s1]   <= 1'b0;
					let_go_q[idx_s1] <= 1'b0;
				end
			end
			if (do_alloc) begin
				held_q[pick]   <= 1'b1;
				let_go_q[pick] <= 1'b0;
				stamp_q        <= stamp_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q     <= cmd;
			chan_ok_q <= (32'(cmd.channel) < vao_pkg::CHANNELS);
		end
		if (state_q == ST_DONE) begin
			result_q.voice         <= do_alloc ? 5'(pick) : 5'd0;
			result_q.steal_kind    <= do_alloc ? kind : vao_pkg::KIND_FREE;
			result_q.affected_mask <= 18'(mask);
			result_q.active_count  <= 5'(count);
		end
	end

	assign done   = done_q;
	assign result = result_q;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while still busy");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy && (state_q == ST_SCAN) && (rd_addr_q == '0))
		else $error("accepted item did not start a scan");

	a_alloc_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		do_alloc |-> $onehot(mask))
		else $error("allocation changed other than one voice");

	a_steal_full: assert property (@(posedge clk) disable iff (!arst_n)
		do_alloc && (kind != vao_pkg::KIND_FREE) |-> (&held_q))
		else $error("voice stolen while a free voice existed");

	a_stamp_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_DONE) |=> $stable(stamp_q))
		else $error("stamp counter moved outside write-back");

endmodule
